/* hw/rtl/assert_macros.svh */
// assertion macros shared by the png scanline unfilter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* hw/rtl/psu_pkg.sv */
// types, constants and helper functions of the png scanline unfilter
`default_nettype none

package psu_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_BPP     = 4;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SLOT_W      = $clog2(MAX_BPP);
	localparam int WIDTH_W     = 13;
	localparam int HEIGHT_W    = 16;
	localparam int BPP_W       = 3;
	localparam int DEPTH_W     = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_BYTES_PER_PIXEL = 2'd2,
		REG_BITS_PER_SAMPLE = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK             = 2'd0,
		ST_BAD_FILTER     = 2'd1,
		ST_SUBBYTE_FILTER = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	// effective configuration after range clamping
	typedef struct packed {
		logic [ADDR_W:0]       spr;
		logic [HEIGHT_W-1:0]   height;
		logic [BPP_W-1:0]      bpp;
		logic [DEPTH_W-1:0]    depth;
	} cfg_t;

	// one classified request from the front to the back
	typedef struct packed {
		logic                err;
		status_t             status;
		logic [7:0]          raw;
		filter_t             filter;
		logic [ADDR_W-1:0]   col;
		logic [SLOT_W-1:0]   slot;
		logic                first_px;
		logic                first_row;
		logic                row_end;
		logic                image_end;
		logic                last;
	} op_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] p, pa, pb, pc;
		logic [7:0] r;
		p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		pa = p - $signed({3'b000, a});
		pb = p - $signed({3'b000, b});
		pc = p - $signed({3'b000, c});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) r = a;
		else if (pb <= pc) r = b;
		else r = c;
		return r;
	endfunction

	// column modulo bytes per pixel, mod 3 by base-4 digit sums
	function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] col,
		input logic [BPP_W-1:0] bpp);
		logic [4:0] s1;
		logic [2:0] s2;
		logic [1:0] m3;
		logic [SLOT_W-1:0] r;
		s1 = '0;
		for (int i = 0; i < ADDR_W / 2; i++) s1 = s1 + 5'(col[2*i +: 2]);
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		if (s2 >= 3'd6) m3 = 2'(s2 - 3'd6);
		else if (s2 >= 3'd3) m3 = 2'(s2 - 3'd3);
		else m3 = s2[1:0];
		case (bpp)
			3'd1: r = '0;
			3'd2: r = SLOT_W'(col[0]);
			3'd3: r = SLOT_W'(m3);
			default: r = col[SLOT_W-1:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/psu_front.sv */
// front end: filter byte parsing, sub-byte unpacking, row and column tracking
`default_nettype none
`include "assert_macros.svh"

module psu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  psu_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_data,
	input  logic            in_start,
	input  logic            q_full,
	output logic            push,
	output psu_pkg::op_t    push_op
);
	import psu_pkg::*;

	logic                  await_q, err_q, busy_q;
	logic [HEIGHT_W-1:0]   row_q;
	logic [ADDR_W-1:0]     col_q;
	filter_t               filter_q;
	logic [7:0]            sh_q;
	logic [2:0]            rem_q;

	logic                  await_e, err_e;
	logic [HEIGHT_W-1:0]   row_e;
	logic [ADDR_W-1:0]     col_e;

	logic                  await_n, err_n, busy_n;
	logic [HEIGHT_W-1:0]   row_n;
	logic [ADDR_W-1:0]     col_n;
	filter_t               filter_n;
	logic [7:0]            sh_n;
	logic [2:0]            rem_n;

	logic                  in_fire, dropped, gen_sample, gen_err, row_done, img_done;
	status_t               code;
	logic [7:0]            cur_byte, raw, cur_shift;
	logic [2:0]            per_m1, rem_after;

	assign in_ready = !busy_q && !q_full;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		await_e = await_q;
		err_e   = err_q;
		row_e   = row_q;
		col_e   = col_q;
		if (in_fire && in_start) begin
			await_e = 1'b1;
			err_e   = 1'b0;
			row_e   = '0;
			col_e   = '0;
		end
	end

	always_comb begin
		dropped = err_e || (row_e >= cfg.height);
		if (in_data > 8'd4) code = ST_BAD_FILTER;
		else if (cfg.depth != DEPTH_FULL && in_data != 8'd0) code = ST_SUBBYTE_FILTER;
		else code = ST_OK;

		cur_byte = busy_q ? sh_q : in_data;
		case (cfg.depth)
			4'd1: begin
				raw       = {7'd0, cur_byte[7]};
				cur_shift = {cur_byte[6:0], 1'b0};
				per_m1    = 3'd7;
			end
			4'd2: begin
				raw       = {6'd0, cur_byte[7:6]};
				cur_shift = {cur_byte[5:0], 2'b00};
				per_m1    = 3'd3;
			end
			4'd4: begin
				raw       = {4'd0, cur_byte[7:4]};
				cur_shift = {cur_byte[3:0], 4'b0000};
				per_m1    = 3'd1;
			end
			default: begin
				raw       = cur_byte;
				cur_shift = '0;
				per_m1    = 3'd0;
			end
		endcase
		rem_after = busy_q ? rem_q - 3'd1 : per_m1;

		gen_sample = busy_q ? !q_full : (in_fire && !dropped && !await_e);
		gen_err    = in_fire && !dropped && await_e && code != ST_OK;
		push       = gen_sample || gen_err;

		row_done = ({1'b0, col_e} + (ADDR_W+1)'(1)) >= cfg.spr;
		img_done = row_done && (({1'b0, row_e} + (HEIGHT_W+1)'(1)) >= {1'b0, cfg.height});
	end

	always_comb begin
		push_op.err       = gen_err;
		push_op.status    = gen_err ? code : ST_OK;
		push_op.raw       = raw;
		push_op.filter    = filter_q;
		push_op.col       = col_e;
		push_op.slot      = slot_of(col_e, cfg.bpp);
		push_op.first_px  = {1'b0, col_e} < (ADDR_W+1)'(cfg.bpp);
		push_op.first_row = row_e == '0;
		push_op.row_end   = !gen_err && row_done;
		push_op.image_end = !gen_err && img_done;
		push_op.last      = gen_err || row_done || rem_after == 3'd0;
	end

	always_comb begin
		await_n  = await_e;
		err_n    = err_e;
		row_n    = row_e;
		col_n    = col_e;
		filter_n = filter_q;
		busy_n   = busy_q;
		sh_n     = sh_q;
		rem_n    = rem_q;
		if (gen_err) err_n = 1'b1;
		if (in_fire && !dropped && await_e && code == ST_OK) begin
			filter_n = filter_t'(in_data[2:0]);
			await_n  = 1'b0;
		end
		if (gen_sample) begin
			if (row_done) begin
				col_n   = '0;
				row_n   = (row_e == '1) ? row_e : row_e + HEIGHT_W'(1);
				await_n = 1'b1;
			end else begin
				col_n = col_e + ADDR_W'(1);
			end
			busy_n = !row_done && rem_after != 3'd0;
			sh_n   = cur_shift;
			rem_n  = rem_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q  <= 1'b1;
			err_q    <= 1'b0;
			busy_q   <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			filter_q <= FLT_NONE;
			sh_q     <= '0;
			rem_q    <= '0;
		end else begin
			await_q  <= await_n;
			err_q    <= err_n;
			busy_q   <= busy_n;
			row_q    <= row_n;
			col_q    <= col_n;
			filter_q <= filter_n;
			sh_q     <= sh_n;
			rem_q    <= rem_n;
		end
	end

	`ASSERT_AT(a_busy_subbyte, clk, arst_n, busy_q |-> cfg.depth != DEPTH_FULL)
	`ASSERT_NEVER(a_err_and_sample, clk, arst_n, gen_err && gen_sample)

endmodule

`default_nettype wire

/* hw/rtl/psu_queue.sv */
// short request queue between front and back
`default_nettype none
`include "assert_macros.svh"

module psu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  psu_pkg::op_t    push_op,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output psu_pkg::op_t    head_op
);
	import psu_pkg::*;

	op_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10: count_q <= count_q + (QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_AT(a_no_overflow, clk, arst_n, push |-> !full || pop)
	`ASSERT_AT(a_no_underflow, clk, arst_n, pop |-> head_valid)

endmodule

`default_nettype wire

/* hw/rtl/psu_back.sv */
// back end: row store, prediction and reconstruction, output register
`default_nettype none
`include "assert_macros.svh"

module psu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  psu_pkg::op_t       q_op,
	output logic               pop,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [7:0]         sample,
	output logic               row_end,
	output logic               image_end,
	output psu_pkg::status_t   status,
	output logic               last
);
	import psu_pkg::*;

	logic [7:0]   row_mem [STORE_DEPTH];
	logic [7:0]   left_q [MAX_BPP];
	logic [7:0]   upleft_q [MAX_BPP];

	logic         v_s1, byp_hit_s1;
	op_t          op_s1;
	logic [7:0]   rdata_s1, byp_s1;

	logic         out_v_q, row_end_q, image_end_q, last_q;
	logic [7:0]   sample_q;
	status_t      status_q;

	logic         advance, wr_en;
	logic [7:0]   a, b, c, pred, val;
	logic [8:0]   avg_sum;

	assign advance = !out_v_q || m_ready;
	assign pop     = advance && q_valid;
	assign wr_en   = advance && v_s1 && !op_s1.err;

	always_comb begin
		a = op_s1.first_px ? 8'd0 : left_q[op_s1.slot];
		b = op_s1.first_row ? 8'd0 : (byp_hit_s1 ? byp_s1 : rdata_s1);
		c = (op_s1.first_row || op_s1.first_px) ? 8'd0 : upleft_q[op_s1.slot];
		avg_sum = {1'b0, a} + {1'b0, b};
		case (op_s1.filter)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = avg_sum[8:1];
			FLT_PAETH: pred = paeth(a, b, c);
			default:   pred = 8'd0;
		endcase
		val = op_s1.raw + pred;
	end

	// row store, read-before-write; same-address hits go through the bypass
	always_ff @(posedge clk) begin
		if (wr_en) row_mem[op_s1.col] <= val;
		if (pop) rdata_s1 <= row_mem[q_op.col];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1      <= q_op;
			byp_hit_s1 <= wr_en && op_s1.col == q_op.col;
			byp_s1     <= val;
		end
		if (advance && v_s1) begin
			sample_q    <= op_s1.err ? 8'd0 : val;
			row_end_q   <= op_s1.row_end;
			image_end_q <= op_s1.image_end;
			status_q    <= op_s1.status;
			last_q      <= op_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < MAX_BPP; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else begin
			if (advance) begin
				v_s1    <= q_valid;
				out_v_q <= v_s1;
			end
			if (wr_en) begin
				left_q[op_s1.slot]   <= val;
				upleft_q[op_s1.slot] <= b;
			end
		end
	end

	assign m_valid   = out_v_q;
	assign sample    = sample_q;
	assign row_end   = row_end_q;
	assign image_end = image_end_q;
	assign status    = status_q;
	assign last      = last_q;

	`ASSERT_AT(a_err_shape, clk, arst_n, m_valid && status != ST_OK |-> sample == 8'd0 && last && !row_end)
	`ASSERT_AT(a_row_end_last, clk, arst_n, m_valid && row_end |-> last)
	`ASSERT_AT(a_img_end_row, clk, arst_n, m_valid && image_end |-> row_end)

endmodule

`default_nettype wire

/* hw/rtl/png_scanline_unfilter_core.sv */
// top level of the png scanline unfilter: config registers, front, queue, back
//
// input stream s_*: one byte of the inflated, filtered image per request;
//   s_tuser high restarts the frame at row 0 and marks the byte as a filter type.
// output stream m_*: one reconstructed sample per request; m_tlast marks the
//   last sample of a row, m_tuser carries the status (nonzero only on the single
//   result that rejects a filter byte, after which the frame is dropped).
// config port: cfg_wr_en writes cfg_wdata into the register at cfg_index at once;
//   write only while no byte is in flight.
// path: samples go through the queue, stage 1 and the output register to m_*.
// throughput: at 8 bits per sample one byte per cycle while the queue has room;
//   at 1, 2 or 4 bits a byte holds the input while its samples are unpacked, and
//   the row's last byte may give fewer samples. filter bytes give no result.
// the row store is a single-port-write, single-port-read memory of 16384 bytes;
//   a same-address read in the same cycle as a write is served from a bypass register.
// reset: config returns to width 1, height 1, 4 bytes per pixel, depth 8; the
//   stream waits for a filter byte; the row store is not cleared.
// a stalled receiver fills the output register and the 4-entry queue, then
//   s_tready drops; nothing is lost.
`default_nettype none

module png_scanline_unfilter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // data_byte
	input  logic                              s_tuser,   // frame_start
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // sample, image_end, last, zero pad
	output logic                              m_tlast,   // row_end
	output logic [1:0]                        m_tuser,   // status
	input  logic                              cfg_wr_en,
	input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import psu_pkg::*;

	logic [WIDTH_W-1:0]    width_q, eff_w;
	logic [HEIGHT_W-1:0]   height_q;
	logic [BPP_W-1:0]      bpp_q, eff_bpp;
	logic [DEPTH_W-1:0]    depth_q;
	cfg_t                  cfg;

	logic                  q_full, push, pop, q_valid;
	op_t                   push_op, q_op;

	logic [7:0]            sample;
	logic                  image_end, last;
	status_t               status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
			bpp_q    <= BPP_W'(4);
			depth_q  <= DEPTH_FULL;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:     width_q  <= cfg_wdata[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:    height_q <= cfg_wdata[HEIGHT_W-1:0];
				REG_BYTES_PER_PIXEL: bpp_q    <= cfg_wdata[BPP_W-1:0];
				REG_BITS_PER_SAMPLE: depth_q  <= cfg_wdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) eff_w = WIDTH_W'(1);
		else if (width_q > WIDTH_W'(MAX_WIDTH)) eff_w = WIDTH_W'(MAX_WIDTH);
		else eff_w = width_q;
		if (bpp_q == '0) eff_bpp = BPP_W'(1);
		else if (bpp_q > BPP_W'(MAX_BPP)) eff_bpp = BPP_W'(MAX_BPP);
		else eff_bpp = bpp_q;
		cfg.spr    = (ADDR_W+1)'(eff_w) * (ADDR_W+1)'(eff_bpp);
		cfg.height = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		cfg.bpp    = eff_bpp;
		case (depth_q)
			4'd1, 4'd2, 4'd4: cfg.depth = depth_q;
			default:          cfg.depth = DEPTH_FULL;
		endcase
	end

	psu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.in_start (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	psu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head_op    (q_op)
	);

	psu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.pop       (pop),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.sample    (sample),
		.row_end   (m_tlast),
		.image_end (image_end),
		.status    (status),
		.last      (last)
	);

	assign m_tdata = {6'd0, last, image_end, sample};
	assign m_tuser = status;

endmodule

`default_nettype wire
